>>> sv/snpc_pkg.sv
// Shared types, constants and helper functions of the shaded palette nearest-colour block.
package snpc_pkg;

  localparam int PAL_ENTRIES = 256;
  localparam int PAL_IDX_W   = $clog2(PAL_ENTRIES);
  localparam int CHAN_W      = 8;
  localparam int FB_W        = 9;
  localparam int SQ_W        = 2 * CHAN_W;
  localparam int DIST_W      = SQ_W + 2;
  localparam int FACTOR_W    = 6;
  localparam int LIGHT_MIN   = -32;
  localparam int LIGHT_MAX   = 31;
  localparam int ROW_BIAS    = 32;
  localparam int ROW_MAX     = 63;
  localparam int ROUND_ADD   = 16;
  localparam int SHADE_SHIFT = 5;
  localparam int CHAN_MAX    = 255;
  localparam int FB_RESET    = 32;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_NEAREST = 2'd1;
  localparam logic [1:0] OP_SHADE   = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0] r;
    logic [CHAN_W-1:0] g;
    logic [CHAN_W-1:0] b;
  } rgb_t;

  // Travels alongside each palette read through the distance pipeline.
  typedef struct packed {
    logic                 valid;
    logic                 last;
    logic [PAL_IDX_W-1:0] idx;
  } tag_t;

  // Scales one channel by the light factor with rounding, saturating at full scale.
  function automatic logic [CHAN_W-1:0] shade_chan(input logic [CHAN_W-1:0]   c,
                                                   input logic [FACTOR_W-1:0] f);
    logic [CHAN_W+FACTOR_W:0]             prod;
    logic [CHAN_W+FACTOR_W-SHADE_SHIFT:0] scaled;
    prod   = (CHAN_W + FACTOR_W + 1)'(c * f) + (CHAN_W + FACTOR_W + 1)'(ROUND_ADD);
    scaled = prod[CHAN_W+FACTOR_W:SHADE_SHIFT];
    if (scaled > (CHAN_W + FACTOR_W - SHADE_SHIFT + 1)'(CHAN_MAX)) begin
      return CHAN_W'(CHAN_MAX);
    end
    return scaled[CHAN_W-1:0];
  endfunction

  // Absolute difference of two channel values.
  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

>>> sv/snpc_palette_mem.sv
// Palette memory: one write port and one read port with registered read data.
module snpc_palette_mem (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [snpc_pkg::PAL_IDX_W-1:0] wr_addr,
  input  snpc_pkg::rgb_t                wr_data,
  input  logic                          rd_en,
  input  logic [snpc_pkg::PAL_IDX_W-1:0] rd_addr,
  output snpc_pkg::rgb_t                rd_data
);
  import snpc_pkg::*;

  rgb_t mem [PAL_ENTRIES];
  rgb_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/snpc_dist.sv
// Two-stage squared colour distance pipeline: squares, then their sum.
module snpc_dist (
  input  logic                        clk,
  input  logic                        rst_n,
  input  snpc_pkg::rgb_t              target,
  input  snpc_pkg::rgb_t              pixel,
  input  snpc_pkg::tag_t              tag_i,
  output logic [snpc_pkg::DIST_W-1:0] dist_o,
  output snpc_pkg::tag_t              tag_o
);
  import snpc_pkg::*;

  logic [SQ_W-1:0]   sq_r_r, sq_g_r, sq_b_r;
  logic [DIST_W-1:0] sum_r;
  tag_t              tag_a_r, tag_b_r;
  logic [CHAN_W-1:0] dr, dg, db;

  always_comb begin
    dr = abs_diff(target.r, pixel.r);
    dg = abs_diff(target.g, pixel.g);
    db = abs_diff(target.b, pixel.b);
  end

  always_ff @(posedge clk) begin
    sq_r_r <= SQ_W'(dr * dr);
    sq_g_r <= SQ_W'(dg * dg);
    sq_b_r <= SQ_W'(db * db);
    sum_r  <= DIST_W'(sq_r_r) + DIST_W'(sq_g_r) + DIST_W'(sq_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_a_r <= '0;
      tag_b_r <= '0;
    end else begin
      tag_a_r <= tag_i;
      tag_b_r <= tag_a_r;
    end
  end

  assign dist_o = sum_r;
  assign tag_o  = tag_b_r;

endmodule

>>> sv/shaded_palette_nearest_color.sv
// Top level of the shaded palette nearest-colour block: control sequencer and result register.
//
// Usage: an input beat carries an operation with its fields. Operation 0 writes one
// palette entry in the cycle it is accepted and gives no result beat. Operation 1
// searches the whole palette for the entry nearest to red, green and blue (sum of
// squared differences, lowest index wins a tie) and gives one result beat.
// Operation 2 reads the entry at color_index, scales it by the clamped light level
// and searches for the nearest entry to the scaled colour; an index among the top
// fullbright_count entries answers with itself at once. Operation 3 is dropped.
// A search reads one palette entry per cycle through the single memory
// read port; operation 2 first reads and scales its entry before its search, and a
// fullbright lookup skips the search and goes straight to the hand-over state.
// The block takes one item at a time; in_stall is high while an item is being
// worked on, from acceptance of operation 1 or 2 until its result is handed to the
// output register, while writes and dropped beats never raise it. The result sits
// in an output register, so the next item is accepted while the previous result still
// waits; a finished search waits for that register to free up if the receiver stalls.
// Reset: rst_n clears the control state and sets fullbright_count to 32; the
// palette contents stay undefined until written. cfg_write_en may be used only
// while the block is idle.
module shaded_palette_nearest_color (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [snpc_pkg::FB_W-1:0]     cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_operation,
  input  logic [snpc_pkg::PAL_IDX_W-1:0] in_color_index,
  input  logic signed [snpc_pkg::CHAN_W-1:0] in_light_level,
  input  logic [snpc_pkg::CHAN_W-1:0]   in_red,
  input  logic [snpc_pkg::CHAN_W-1:0]   in_green,
  input  logic [snpc_pkg::CHAN_W-1:0]   in_blue,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [snpc_pkg::PAL_IDX_W-1:0] out_result_index
);
  import snpc_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SHADE  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [FB_W-1:0]      fb_r;
  logic [PAL_IDX_W-1:0] cnt_r, cnt_nxt;
  rgb_t                 tgt_r, tgt_nxt;
  logic [FACTOR_W-1:0]  factor_r, factor_nxt;
  logic [PAL_IDX_W-1:0] res_r, res_nxt;
  logic [DIST_W-1:0]    near_dist_r, near_dist_nxt;
  logic [PAL_IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [PAL_IDX_W-1:0] out_idx_r, out_idx_nxt;

  logic                 accept;
  logic                 fullbright;
  logic [FACTOR_W-1:0]  row;
  logic                 mem_we, mem_re;
  logic [PAL_IDX_W-1:0] mem_raddr;
  rgb_t                 mem_wdata, mem_rdata;
  tag_t                 tag_0, tag_1_r, tag_b;
  logic [DIST_W-1:0]    dist_b;
  logic                 take;
  logic                 out_load;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // An index is fullbright when it falls among the top fullbright_count entries.
  assign fullbright = (10'(in_color_index) + 10'(fb_r)) >= 10'(PAL_ENTRIES);

  // Light is clamped to its legal span and turned into a row of the colour ramp.
  always_comb begin
    if (in_light_level < LIGHT_MIN) begin
      row = '0;
    end else if (in_light_level > LIGHT_MAX) begin
      row = FACTOR_W'(ROW_MAX);
    end else begin
      row = FACTOR_W'(in_light_level + CHAN_W'(ROW_BIAS));
    end
  end

  // Palette writes happen in the accepting cycle; the memory is otherwise only read.
  assign mem_we    = accept && (in_operation == OP_WRITE) &&
                     (32'(in_color_index) < PAL_ENTRIES);
  assign mem_wdata = '{r: in_red, g: in_green, b: in_blue};
  assign mem_re    = (accept && (in_operation == OP_SHADE)) || (state_r == S_SEARCH);
  assign mem_raddr = (state_r == S_IDLE) ? in_color_index : cnt_r;

  snpc_palette_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (in_color_index),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // The tag of each read issued in the search sweep follows it through the pipeline.
  always_comb begin
    tag_0.valid = (state_r == S_SEARCH);
    tag_0.last  = (state_r == S_SEARCH) && (cnt_r == PAL_IDX_W'(PAL_ENTRIES - 1));
    tag_0.idx   = cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_1_r <= '0;
    end else begin
      tag_1_r <= tag_0;
    end
  end

  snpc_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .target (tgt_r),
    .pixel  (mem_rdata),
    .tag_i  (tag_1_r),
    .dist_o (dist_b),
    .tag_o  (tag_b)
  );

  // Running minimum; the first entry always seeds it and later ones must be strictly nearer.
  assign take = tag_b.valid && ((tag_b.idx == '0) || (dist_b < near_dist_r));

  always_comb begin
    near_dist_nxt = near_dist_r;
    best_idx_nxt  = best_idx_r;
    if (take) begin
      near_dist_nxt = dist_b;
      best_idx_nxt  = tag_b.idx;
    end
  end

  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    tgt_nxt    = tgt_r;
    factor_nxt = factor_r;
    res_nxt    = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            OP_NEAREST: begin
              tgt_nxt   = '{r: in_red, g: in_green, b: in_blue};
              cnt_nxt   = '0;
              state_nxt = S_SEARCH;
            end
            OP_SHADE: begin
              factor_nxt = FACTOR_W'(ROW_MAX) - row;
              if (fullbright) begin
                res_nxt   = in_color_index;
                state_nxt = S_DONE;
              end else begin
                state_nxt = S_SHADE;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SHADE: begin
        tgt_nxt.r = shade_chan(mem_rdata.r, factor_r);
        tgt_nxt.g = shade_chan(mem_rdata.g, factor_r);
        tgt_nxt.b = shade_chan(mem_rdata.b, factor_r);
        cnt_nxt   = '0;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        cnt_nxt = cnt_r + 1'b1;
        if (tag_0.last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (tag_b.valid && tag_b.last) begin
          res_nxt   = best_idx_nxt;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = res_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fb_r        <= FB_W'(FB_RESET);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_write_en) begin
        fb_r <= cfg_write_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    tgt_r       <= tgt_nxt;
    factor_r    <= factor_nxt;
    res_r       <= res_nxt;
    near_dist_r <= near_dist_nxt;
    best_idx_r  <= best_idx_nxt;
    out_idx_r   <= out_idx_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_idx_r;

  // A result beat only ever appears straight after the sequencer hands one over.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result beat raised outside the hand-over state");

  // The last entry of a sweep reaches the comparator only once the sweep has ended.
  a_last_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (tag_b.valid && tag_b.last) |-> state_r == S_DRAIN)
    else $error("final distance arrived outside the drain state");

  // Every sweep starts at the first palette entry.
  a_sweep_from_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH && $past(state_r) != S_SEARCH) |-> cnt_r == '0)
    else $error("palette sweep did not start at entry zero");

  // The palette is never written while a search or shade is under way.
  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == S_IDLE)
    else $error("palette written while busy");

endmodule

>>> dv/palette_result_checker.sv
`timescale 1ns / 100ps
// Checker for the shaded palette block: tracks palette and fullbright count, predicts each result.
module palette_result_checker (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_write_en,
  input  logic [snpc_pkg::FB_W-1:0]            cfg_write_data,
  input  logic                                 in_valid,
  input  logic                                 in_stall,
  input  logic [1:0]                           in_operation,
  input  logic [snpc_pkg::PAL_IDX_W-1:0]       in_color_index,
  input  logic signed [snpc_pkg::CHAN_W-1:0]   in_light_level,
  input  logic [snpc_pkg::CHAN_W-1:0]          in_red,
  input  logic [snpc_pkg::CHAN_W-1:0]          in_green,
  input  logic [snpc_pkg::CHAN_W-1:0]          in_blue,
  input  logic                                 out_valid,
  input  logic                                 out_stall,
  input  logic [snpc_pkg::PAL_IDX_W-1:0]       out_result_index,
  output int                                   fail_count,
  output int                                   pending
);
  import snpc_pkg::*;

  rgb_t                 palette_copy [PAL_ENTRIES];
  logic [FB_W-1:0]      fullbright_cnt = FB_W'(FB_RESET);
  logic [PAL_IDX_W-1:0] pending_indices [$];
  logic [PAL_IDX_W-1:0] want_index;
  int                   mismatches = 0;

  function automatic int chan_sq(int a, int b);
    return (a - b) * (a - b);
  endfunction

  // Lowest index wins a tie, hence the strict comparison.
  function automatic logic [PAL_IDX_W-1:0] nearest_entry(rgb_t c);
    int                   err;
    int                   min_err;
    logic [PAL_IDX_W-1:0] best;
    best    = '0;
    min_err = 0;
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      err = chan_sq(c.r, palette_copy[i].r) + chan_sq(c.g, palette_copy[i].g) +
            chan_sq(c.b, palette_copy[i].b);
      if (i == 0 || err < min_err) begin
        best    = PAL_IDX_W'(i);
        min_err = err;
      end
    end
    return best;
  endfunction

  function automatic logic [CHAN_W-1:0] scaled_chan(int c, int factor);
    int v;
    v = (c * factor + ROUND_ADD) >> SHADE_SHIFT;
    if (v > CHAN_MAX) v = CHAN_MAX;
    return CHAN_W'(v);
  endfunction

  function automatic logic [PAL_IDX_W-1:0] shaded_entry(logic [PAL_IDX_W-1:0] idx,
                                                        logic signed [CHAN_W-1:0] light_raw);
    int   light;
    int   factor;
    rgb_t lit;
    if (int'(idx) + int'(fullbright_cnt) >= PAL_ENTRIES) return idx;
    light = light_raw;
    if (light < LIGHT_MIN) light = LIGHT_MIN;
    if (light > LIGHT_MAX) light = LIGHT_MAX;
    factor = ROW_MAX - (light + ROW_BIAS);
    lit.r  = scaled_chan(palette_copy[idx].r, factor);
    lit.g  = scaled_chan(palette_copy[idx].g, factor);
    lit.b  = scaled_chan(palette_copy[idx].b, factor);
    return nearest_entry(lit);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      fullbright_cnt = FB_W'(FB_RESET);
      pending_indices.delete();
    end else begin
      // Results are checked before new beats are logged, so a spurious result is never
      // matched against an expectation queued at the same edge.
      if (out_valid && !out_stall) begin
        if (pending_indices.size() == 0) begin
          $error("result_index: beat with nothing outstanding, expected none, actual %0d",
                 out_result_index);
          mismatches++;
        end else begin
          want_index = pending_indices.pop_front();
          if (out_result_index !== want_index) begin
            $error("result_index mismatch: expected %0d, actual %0d",
                   want_index, out_result_index);
            mismatches++;
          end
        end
      end
      if (cfg_write_en) fullbright_cnt = cfg_write_data;
      if (in_valid && !in_stall) begin
        case (in_operation)
          OP_WRITE:   palette_copy[in_color_index] = {in_red, in_green, in_blue};
          OP_NEAREST: pending_indices.push_back(nearest_entry({in_red, in_green, in_blue}));
          OP_SHADE:   pending_indices.push_back(shaded_entry(in_color_index, in_light_level));
          default: ;
        endcase
      end
    end
    fail_count <= mismatches;
    pending    <= pending_indices.size();
  end

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for the shaded palette block: stimulus, flow control, timeout and verdict.
module tb_top;
  import snpc_pkg::*;

  // Operation 3 has no name in the package; the block must drop it silently.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int ITEMS_PER_PHASE = 220;
  // Used for the final settle, to cover a shaded search.
  localparam int SEARCH_CYCLES   = 262;
  // Writes and dropped beats give no result and never raise in_stall.
  localparam int CFG_SETTLE      = 4;
  // Long enough to cover two complete searches, so the output register and the finished
  // search both back up and the block has to stall its input.
  localparam int HOLD_CYCLES     = 1500;
  localparam int CYCLE_LIMIT     = 3_000_000;

  logic                     clk            = 1'b0;
  logic                     rst_n          = 1'b0;
  logic                     cfg_write_en   = 1'b0;
  logic [FB_W-1:0]          cfg_write_data = '0;
  logic                     in_valid       = 1'b0;
  logic [1:0]               in_operation   = OP_WRITE;
  logic [PAL_IDX_W-1:0]     in_color_index = '0;
  logic signed [CHAN_W-1:0] in_light_level = '0;
  logic [CHAN_W-1:0]        in_red         = '0;
  logic [CHAN_W-1:0]        in_green       = '0;
  logic [CHAN_W-1:0]        in_blue        = '0;
  logic                     out_stall      = 1'b0;
  logic                     in_stall;
  logic                     out_valid;
  logic [PAL_IDX_W-1:0]     out_result_index;

  int fail_count;
  int pending;

  // Flow-control knobs, changed between phases.
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_asked  = 0;
  int hold_served = 0;
  int hold_left   = 0;
  int cycle_count = 0;

  // Shadow of the fullbright count, used only to aim shaded lookups at its boundary.
  logic [FB_W-1:0] cur_fb = FB_W'(FB_RESET);

  always #6 clk = ~clk;

  shaded_palette_nearest_color i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_color_index   (in_color_index),
    .in_light_level   (in_light_level),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index)
  );

  palette_result_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_color_index   (in_color_index),
    .in_light_level   (in_light_level),
    .in_red           (in_red),
    .in_green         (in_green),
    .in_blue          (in_blue),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_index (out_result_index),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  // Receiver. A requested hold-off is counted down here, one cycle at a time; otherwise
  // the stall is drawn at random each cycle at the current percentage.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one beat and returns at the edge where it is taken. Any idle gap comes first,
  // so valid is only ever lowered between beats, never while one is waiting. Now and then
  // the gap is long, so that it lands somewhere inside a search rather than just after an
  // acceptance.
  task automatic put_beat(logic [1:0] op, logic [PAL_IDX_W-1:0] idx,
                          logic signed [CHAN_W-1:0] light, rgb_t c);
    int gap;
    gap = 0;
    if (idle_pct > 0) begin
      if ($urandom_range(0, 7) == 0) gap = $urandom_range(1, 300);
      else while ($urandom_range(0, 99) < idle_pct) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_color_index <= idx;
    in_light_level <= light;
    in_red         <= c.r;
    in_green       <= c.g;
    in_blue        <= c.b;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every predicted result has been taken, then lets the
  // block finish any trailing write or dropped beat.
  task automatic wait_idle(int settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic set_fullbright(logic [FB_W-1:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    cur_fb = v;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // A coarse channel takes one of six evenly spaced levels, which makes duplicate palette
  // entries and exact-match queries common, so that the tie rule gets exercised.
  function automatic logic [CHAN_W-1:0] pick_chan(int coarse_pct);
    if ($urandom_range(0, 99) < coarse_pct) return CHAN_W'(51 * $urandom_range(0, 5));
    return CHAN_W'($urandom_range(0, CHAN_MAX));
  endfunction

  function automatic rgb_t pick_colour(int coarse_pct);
    rgb_t c;
    c.r = pick_chan(coarse_pct);
    c.g = pick_chan(coarse_pct);
    c.b = pick_chan(coarse_pct);
    return c;
  endfunction

  // Mostly just around the clamp limits, sometimes anywhere in the signed byte.
  function automatic logic signed [CHAN_W-1:0] pick_light();
    if ($urandom_range(0, 4) != 0) return CHAN_W'(int'($urandom_range(0, 80)) - 40);
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  // A quarter of shaded lookups sit on the edge between shaded and fullbright indices.
  function automatic logic [PAL_IDX_W-1:0] pick_shade_index();
    int idx;
    if ($urandom_range(0, 3) != 0) return PAL_IDX_W'($urandom_range(0, PAL_ENTRIES - 1));
    idx = PAL_ENTRIES - int'(cur_fb) + int'($urandom_range(0, 3)) - 2;
    if (idx < 0) idx = 0;
    if (idx > PAL_ENTRIES - 1) idx = PAL_ENTRIES - 1;
    return PAL_IDX_W'(idx);
  endfunction

  // Every entry is written before any search, as a search reads the whole palette.
  task automatic load_palette(int coarse_pct);
    for (int i = 0; i < PAL_ENTRIES; i++) begin
      put_beat(OP_WRITE, PAL_IDX_W'(i), pick_light(), pick_colour(coarse_pct));
    end
  endtask

  // Palette rewrites, searches and shaded lookups mixed, with the odd dropped beat that
  // does not count towards the total.
  task automatic run_random(int n_items, int coarse_pct);
    int done;
    int roll;
    done = 0;
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) begin
        put_beat(OP_UNUSED, PAL_IDX_W'($urandom), pick_light(), pick_colour(0));
      end else begin
        if (roll < 30) begin
          put_beat(OP_WRITE, PAL_IDX_W'($urandom), pick_light(), pick_colour(coarse_pct));
        end else if (roll < 65) begin
          put_beat(OP_NEAREST, PAL_IDX_W'($urandom), pick_light(), pick_colour(coarse_pct));
        end else begin
          put_beat(OP_SHADE, pick_shade_index(), pick_light(), pick_colour(0));
        end
        done++;
      end
    end
  endtask

  // One random phase: new fullbright count while idle, new flow-control mix, then random
  // traffic whose palette rewrites follow the phase's colour mix.
  task automatic run_phase(int idle, int stall, logic [FB_W-1:0] fb, int coarse_pct);
    wait_idle(CFG_SETTLE);
    set_fullbright(fb);
    idle_pct = idle;
    stall_pct <= stall;
    run_random(ITEMS_PER_PHASE, coarse_pct);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, under the fullbright count left by reset. Known colours are planted
    // at a few indices: pure black and white at the ends, a duplicated colour for the tie
    // rule and a mid-range colour to shade.
    load_palette(50);
    put_beat(OP_WRITE, 8'd0,   CHAN_W'(0), rgb_t'{8'd0,   8'd0,   8'd0});
    put_beat(OP_WRITE, 8'd255, CHAN_W'(0), rgb_t'{8'd255, 8'd255, 8'd255});
    put_beat(OP_WRITE, 8'd7,   CHAN_W'(0), rgb_t'{8'd10,  8'd20,  8'd30});
    put_beat(OP_WRITE, 8'd130, CHAN_W'(0), rgb_t'{8'd10,  8'd20,  8'd30});
    put_beat(OP_WRITE, 8'd100, CHAN_W'(0), rgb_t'{8'd200, 8'd100, 8'd50});
    put_beat(OP_NEAREST, 8'd0, CHAN_W'(0), rgb_t'{8'd0,   8'd0,   8'd0});
    put_beat(OP_NEAREST, 8'd0, CHAN_W'(0), rgb_t'{8'd255, 8'd255, 8'd255});
    put_beat(OP_NEAREST, 8'd0, CHAN_W'(0), rgb_t'{8'd10,  8'd20,  8'd30});
    put_beat(OP_NEAREST, 8'd0, CHAN_W'(0), rgb_t'{8'd11,  8'd21,  8'd29});
    // Light below, at and above both clamp limits; row 0 saturates the red channel.
    put_beat(OP_SHADE, 8'd100, CHAN_W'(-128), rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_SHADE, 8'd100, CHAN_W'(-33),  rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_SHADE, 8'd100, CHAN_W'(-32),  rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_SHADE, 8'd100, CHAN_W'(0),    rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_SHADE, 8'd100, CHAN_W'(31),   rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_SHADE, 8'd100, CHAN_W'(32),   rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_SHADE, 8'd100, CHAN_W'(127),  rgb_t'{8'd0, 8'd0, 8'd0});
    // Last shaded index, first fullbright index and the top index at the reset count.
    put_beat(OP_SHADE, 8'd223, CHAN_W'(-5), rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_SHADE, 8'd224, CHAN_W'(-5), rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_SHADE, 8'd255, CHAN_W'(-5), rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_UNUSED, 8'd255, CHAN_W'(-1), rgb_t'{8'd255, 8'd255, 8'd255});

    // No fullbright entries: even the top index is shaded.
    wait_idle(CFG_SETTLE);
    set_fullbright(9'd0);
    put_beat(OP_SHADE, 8'd255, CHAN_W'(5), rgb_t'{8'd0, 8'd0, 8'd0});
    // A count of the whole palette makes every index fullbright.
    wait_idle(CFG_SETTLE);
    set_fullbright(9'd256);
    put_beat(OP_SHADE, 8'd0, CHAN_W'(-10), rgb_t'{8'd0, 8'd0, 8'd0});
    // One short of the whole palette: only index 0 is still shaded.
    wait_idle(CFG_SETTLE);
    set_fullbright(9'd255);
    put_beat(OP_SHADE, 8'd0, CHAN_W'(3), rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_SHADE, 8'd1, CHAN_W'(3), rgb_t'{8'd0, 8'd0, 8'd0});
    wait_idle(CFG_SETTLE);
    set_fullbright(9'd1);
    put_beat(OP_SHADE, 8'd254, CHAN_W'(-20), rgb_t'{8'd0, 8'd0, 8'd0});
    put_beat(OP_SHADE, 8'd255, CHAN_W'(-20), rgb_t'{8'd0, 8'd0, 8'd0});

    // Random phases: free running, idle sender, stalling receiver, then both together.
    run_phase(0,  0,  9'd0,   80);
    run_phase(72, 0,  9'd200, 0);
    run_phase(0,  72, FB_W'($urandom_range(0, PAL_ENTRIES)), 60);
    run_phase(35, 35, 9'd1,   30);

    // Back-pressure: the receiver holds off for a long stretch while beats keep coming, so
    // the block fills up and has to stall its input.
    wait_idle(CFG_SETTLE);
    set_fullbright(FB_W'(FB_RESET));
    idle_pct = 0;
    stall_pct  <= 0;
    hold_asked <= hold_asked + 1;
    run_random(ITEMS_PER_PHASE, 70);

    // Everything has been taken; leave time for any stray result to show up.
    wait_idle(SEARCH_CYCLES + 40);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/snpc_pkg.sv
sv/snpc_palette_mem.sv
sv/snpc_dist.sv
sv/shaded_palette_nearest_color.sv
dv/palette_result_checker.sv
dv/tb_top.sv
